// ===== src/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the pedal sensor calibrator.
// ----------------------------------------------------------------------------
package psc_pkg;

  typedef enum logic [1:0] {
    MODE_RUN   = 2'd0,
    MODE_RANGE = 2'd1,
    MODE_CHAR  = 2'd2,
    MODE_SAVED = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRAME,
    ST_BIN_DIV,
    ST_RD,
    ST_MEAN_ONE,
    ST_MEAN_TWO,
    ST_WR,
    ST_CHECK,
    ST_STATUS
  } state_e;

  localparam logic [1:0] CFG_GAP    = 2'd0;
  localparam logic [1:0] CFG_MAXBIN = 2'd1;
  localparam logic [1:0] CFG_PERIOD = 2'd2;

  localparam logic [7:0] SYNC_BYTE  = 8'hAA;
  localparam logic [7:0] START_BYTE = 8'hAB;
  localparam logic [7:0] END_BYTE   = 8'hBA;

  // start/done handshake to the shared divider
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// ===== src/psc_divider.sv =====
// ----------------------------------------------------------------------------
// psc_divider
// Restoring divider, one quotient bit per cycle, shared by bin mapping
// and bin means.
// ----------------------------------------------------------------------------
module psc_divider #(
  parameter int unsigned W = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output psc_pkg::div_ctl_t ctl_o,
  output logic [W-1:0] quo_o
);
  import psc_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W:0]    trial;

  // one shift-subtract step per cycle
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[W-1]} - {1'b0, den_q};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o       = quo_q;
  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign ctl_o.done  = done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_q)
    else $error("divider did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> cnt_q != '0)
    else $error("divider count underflow");

endmodule

// ===== src/pedal_sensor_calibrator.sv =====
// ----------------------------------------------------------------------------
// pedal_sensor_calibrator
// Pedal sensor framing, range tracking and characterization.
// ----------------------------------------------------------------------------
// One item at a time. A running-mode sample streams 16 frame bytes, one per
// cycle the output is taken. A characterization sample runs the shared
// bit-serial divider up to three times (bin mapping and two means), and on
// check steps then walks all NUM_BINS fill entries one per cycle.
// After reset, a clearing pass over all NUM_BINS entries empties the bin
// memory before the first item is accepted.
module pedal_sensor_calibrator #(
  parameter int unsigned NUM_BINS    = 100,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [7:0]             cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   op_i,
  input  logic [SAMPLE_BITS-1:0] pot_one_i,
  input  logic [SAMPLE_BITS-1:0] pot_two_i,
  input  logic [SAMPLE_BITS-1:0] angle_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   is_frame_o,
  output logic [7:0]             out_byte_o,
  output logic                   last_o,
  output logic [1:0]             mode_o,
  output logic [6:0]             bin_index_o,
  output logic [6:0]             filled_bins_o,
  output logic                   coverage_ok_o,
  output logic [SAMPLE_BITS:0]   low_one_o,
  output logic [SAMPLE_BITS:0]   high_one_o,
  output logic [SAMPLE_BITS:0]   low_two_o,
  output logic [SAMPLE_BITS:0]   high_two_o
);
  import psc_pkg::*;

  localparam int unsigned SW = SAMPLE_BITS;
  localparam int unsigned BW = $clog2(NUM_BINS);
  localparam int unsigned NW = $clog2(NUM_BINS + 1);
  localparam int unsigned DW = SW + 1 + $clog2(NUM_BINS) + 1;
  localparam logic [SW:0] FULL = {1'b1, {SW{1'b0}}};

  // configuration
  logic [6:0] gap_q, maxbin_q;
  logic [7:0] period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q    <= 7'd13;
      maxbin_q <= 7'd5;
      period_q <= 8'd5;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GAP:    gap_q    <= cfg_data_i[6:0];
        CFG_MAXBIN: maxbin_q <= cfg_data_i[6:0];
        CFG_PERIOD: period_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // bin memories
  logic [SW-1:0] mem_one [NUM_BINS];
  logic [SW-1:0] mem_two [NUM_BINS];
  logic [6:0]    mem_fill [NUM_BINS];
  logic [SW-1:0] rd_one_q, rd_two_q;
  logic [6:0]    rd_fill_q;
  logic [BW-1:0] addr;
  logic          we;
  logic [SW-1:0] wr_one, wr_two;
  logic [6:0]    wr_fill;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_one[addr]  <= wr_one;
      mem_two[addr]  <= wr_two;
      mem_fill[addr] <= wr_fill;
    end
    rd_one_q  <= mem_one[addr];
    rd_two_q  <= mem_two[addr];
    rd_fill_q <= mem_fill[addr];
  end

  // state
  state_e st_q, st_d;
  mode_e  mode_q, mode_d;
  logic [SW:0] min1_q, max1_q, min2_q, max2_q;
  logic [SW:0] min1_d, max1_d, min2_d, max2_d;
  logic [6:0]  filled_q, filled_d;
  logic [7:0]  chk_q, chk_d;
  logic        clr_q, clr_d;
  logic [NW-1:0] ptr_q, ptr_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic        top_empty_q, top_empty_d;
  logic [3:0]  fidx_q, fidx_d;
  logic        ok_q, ok_d;
  logic [BW-1:0] bin_q, bin_d;
  logic        op_q;
  logic [SW-1:0] p1_q, p2_q, ang_q;
  logic [SW-1:0] m1_q, m1_d;

  logic          div_start;
  logic [DW-1:0] div_num, div_den, div_quo;
  div_ctl_t      div_ctl;

  psc_divider #(.W(DW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .ctl_o(div_ctl), .quo_o(div_quo)
  );

  logic accept;
  assign accept = in_valid_i && in_ready_o;

  // frame byte
  logic [7:0] csum, fbyte;
  assign csum = 8'({4'b0, ang_q} >> 8) + 8'(ang_q) + 8'({4'b0, p1_q} >> 8) + 8'(p1_q)
              + 8'({4'b0, p2_q} >> 8) + 8'(p2_q);
  always_comb begin
    case (fidx_q)
      4'd7:    fbyte = START_BYTE;
      4'd8:    fbyte = 8'({4'b0, ang_q} >> 8);
      4'd9:    fbyte = 8'(ang_q);
      4'd10:   fbyte = 8'({4'b0, p1_q} >> 8);
      4'd11:   fbyte = 8'(p1_q);
      4'd12:   fbyte = 8'({4'b0, p2_q} >> 8);
      4'd13:   fbyte = 8'(p2_q);
      4'd14:   fbyte = csum;
      4'd15:   fbyte = END_BYTE;
      default: fbyte = SYNC_BYTE;
    endcase
  end

  logic [7:0]  nb_one;
  assign nb_one = {1'b0, rd_fill_q} + 8'd1;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:
        if (accept) begin
          if (op_i || mode_q == MODE_RANGE || mode_q == MODE_SAVED) st_d = ST_STATUS;
          else if (mode_q == MODE_RUN) st_d = ST_FRAME;
          else st_d = ST_BIN_DIV;
        end
      ST_FRAME:    if (out_ready_i && fidx_q == 4'd15) st_d = ST_IDLE;
      ST_BIN_DIV:  if (div_ctl.done) st_d = ST_RD;
      ST_RD:       st_d = (rd_fill_q < maxbin_q) ? ST_MEAN_ONE : ST_WR;
      ST_MEAN_ONE: if (div_ctl.done) st_d = ST_MEAN_TWO;
      ST_MEAN_TWO: if (div_ctl.done) st_d = ST_WR;
      ST_WR:       st_d = (chk_q == period_q) ? ST_CHECK : ST_STATUS;
      ST_CHECK:    if (ptr_q == NW'(NUM_BINS)) st_d = ST_STATUS;
      ST_STATUS:   if (out_ready_i) st_d = ST_IDLE;
      default:     st_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    mode_d = mode_q; min1_d = min1_q; max1_d = max1_q; min2_d = min2_q;
    max2_d = max2_q; filled_d = filled_q; chk_d = chk_q; clr_d = clr_q;
    ptr_d = ptr_q; cnt_d = cnt_q; top_empty_d = top_empty_q; fidx_d = fidx_q;
    ok_d = ok_q; bin_d = bin_q; m1_d = m1_q;
    div_start = 1'b0; div_num = '0; div_den = '0;
    we = 1'b0; addr = bin_q; wr_one = '0; wr_two = '0; wr_fill = '0;
    case (st_q)
      ST_IDLE: begin
        if (clr_q) begin
          we = 1'b1; addr = BW'(ptr_q); ptr_d = ptr_q + 1'b1;
          if (ptr_q == NW'(NUM_BINS - 1)) clr_d = 1'b0;
        end
        fidx_d = '0; ok_d = 1'b0; bin_d = '0;
        if (accept) begin
          if (op_i) begin
            if (mode_q == MODE_RUN) begin
              max1_d = '0; min1_d = FULL; max2_d = '0; min2_d = FULL;
            end
            mode_d = MODE_RANGE;
          end else if (mode_q == MODE_RANGE) begin
            if ({1'b0, pot_one_i} > max1_q) max1_d = {1'b0, pot_one_i};
            if ({1'b0, pot_one_i} < min1_q) min1_d = {1'b0, pot_one_i};
            if ({1'b0, pot_two_i} > max2_q) max2_d = {1'b0, pot_two_i};
            if ({1'b0, pot_two_i} < min2_q) min2_d = {1'b0, pot_two_i};
          end else if (mode_q == MODE_CHAR) begin
            div_start = 1'b1;
            div_num = DW'(({1'b0, pot_one_i} - min1_q)) * DW'(NUM_BINS);
            div_den = DW'(max1_q - min1_q);
          end
        end
      end
      ST_FRAME: if (out_ready_i) fidx_d = fidx_q + 1'b1;
      ST_BIN_DIV:
        if (div_ctl.done) begin
          if (max1_q <= min1_q || {1'b0, p1_q} <= min1_q) bin_d = '0;
          else if (div_quo > DW'(NUM_BINS - 1)) bin_d = BW'(NUM_BINS - 1);
          else bin_d = BW'(div_quo);
          addr = bin_d;
        end
      ST_RD: begin
        div_start = rd_fill_q < maxbin_q;
        div_num = DW'(rd_one_q) * DW'(rd_fill_q) + DW'(p1_q);
        div_den = DW'(nb_one);
      end
      ST_MEAN_ONE:
        if (div_ctl.done) begin
          m1_d = SW'(div_quo);
          div_start = 1'b1;
          div_num = DW'(rd_two_q) * DW'(rd_fill_q) + DW'(p2_q);
          div_den = DW'(nb_one);
        end
      ST_MEAN_TWO: ;
      ST_WR: begin
        if (rd_fill_q < maxbin_q) begin
          we = 1'b1; wr_one = m1_q; wr_two = SW'(div_quo); wr_fill = rd_fill_q + 1'b1;
          if (rd_fill_q == '0) filled_d = filled_q + 1'b1;
        end
        ptr_d = '0; cnt_d = '0; top_empty_d = 1'b0;
        if (chk_q == period_q) chk_d = 8'd1;
        else chk_d = chk_q + 1'b1;
      end
      ST_CHECK: begin
        // read one fill entry a cycle; count the one read last cycle
        addr = BW'(ptr_q);
        if (ptr_q != NW'(NUM_BINS)) ptr_d = ptr_q + 1'b1;
        if (ptr_q != '0 && rd_fill_q != '0) cnt_d = cnt_q + 1'b1;
        if (ptr_q == NW'(NUM_BINS)) begin
          top_empty_d = rd_fill_q == '0;
          if (10 * (NUM_BINS + ((rd_fill_q == '0) ? 1 : 0))
              < int'(gap_q) * (int'(cnt_d) + 1)) begin
            ok_d = 1'b1; mode_d = MODE_SAVED;
          end
        end
      end
      ST_STATUS: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; mode_q <= MODE_CHAR;
      min1_q <= '0; max1_q <= FULL; min2_q <= '0; max2_q <= FULL;
      filled_q <= '0; chk_q <= 8'd1; clr_q <= 1'b1; ptr_q <= '0; cnt_q <= '0;
      top_empty_q <= 1'b0; fidx_q <= '0; ok_q <= 1'b0; bin_q <= '0;
    end else begin
      st_q <= st_d; mode_q <= mode_d;
      min1_q <= min1_d; max1_q <= max1_d; min2_q <= min2_d; max2_q <= max2_d;
      filled_q <= filled_d; chk_q <= chk_d; clr_q <= clr_d; ptr_q <= ptr_d;
      cnt_q <= cnt_d; top_empty_q <= top_empty_d; fidx_q <= fidx_d;
      ok_q <= ok_d; bin_q <= bin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q <= m1_d;
    if (accept) begin
      op_q <= op_i; p1_q <= pot_one_i; p2_q <= pot_two_i; ang_q <= angle_i;
    end
  end

  // outputs
  assign in_ready_o    = st_q == ST_IDLE && !clr_q;
  assign out_valid_o   = st_q == ST_FRAME || st_q == ST_STATUS;
  assign is_frame_o    = st_q == ST_FRAME;
  assign out_byte_o    = (st_q == ST_FRAME) ? fbyte : 8'd0;
  assign last_o        = st_q == ST_STATUS || fidx_q == 4'd15;
  assign mode_o        = mode_q;
  assign bin_index_o   = 7'(bin_q);
  assign filled_bins_o = filled_q;
  assign coverage_ok_o = ok_q && !op_q && !top_empty_q | ok_q;
  assign low_one_o     = min1_q;
  assign high_one_o    = max1_q;
  assign low_two_o     = min2_q;
  assign high_two_o    = max2_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) clr_q |-> !in_ready_o)
    else $error("item accepted during clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> !out_valid_o)
    else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_FRAME |-> mode_q == MODE_RUN)
    else $error("frame outside running mode");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pedal_sensor_calibrator. A behavioral copy of the
// calibrator predicts every status/frame result for each accepted item, and
// a scoreboard compares outputs in order. Stimulus covers characterization
// binning, the per-bin cap, coverage checks into saved mode and range mode.
// ----------------------------------------------------------------------------
module tb_top;
  import psc_pkg::*;

  localparam int unsigned NBINS = 100;
  localparam int unsigned SBITS = 12;
  localparam int unsigned FULL  = 1 << SBITS;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 250;

  typedef struct packed {
    logic        is_frame;
    logic [7:0]  out_byte;
    logic        last;
    logic [1:0]  mode;
    logic [6:0]  bin_index;
    logic [6:0]  filled_bins;
    logic        coverage_ok;
    logic [12:0] low_one;
    logic [12:0] high_one;
    logic [12:0] low_two;
    logic [12:0] high_two;
  } calib_result_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic in_valid_i, in_ready_o, op_i;
  logic [SBITS-1:0] pot_one_i, pot_two_i, angle_i;
  logic out_valid_o, out_ready_i;
  logic is_frame_o, last_o, coverage_ok_o;
  logic [7:0] out_byte_o;
  logic [1:0] mode_o;
  logic [6:0] bin_index_o, filled_bins_o;
  logic [SBITS:0] low_one_o, high_one_o, low_two_o, high_two_o;

  pedal_sensor_calibrator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .op_i, .pot_one_i, .pot_two_i, .angle_i,
    .out_valid_o, .out_ready_i, .is_frame_o, .out_byte_o, .last_o, .mode_o,
    .bin_index_o, .filled_bins_o, .coverage_ok_o,
    .low_one_o, .high_one_o, .low_two_o, .high_two_o
  );

  // Shadow copy of the calibrator state and registers
  int unsigned gap_limit, cap_per_bin, period;
  logic [1:0]  cur_mode;
  int unsigned lo1, hi1, lo2, hi2;
  int unsigned mean_one [NBINS];
  int unsigned mean_two [NBINS];
  int unsigned fill_cnt [NBINS];
  int unsigned nfilled, period_cnt;

  calib_result_t pending_results[$];
  int unsigned   errors, mismatches, items_sent, results_seen;
  int unsigned   frames_seen, saves_seen;
  int unsigned   burst_left;
  int unsigned   hold_cycles;
  int unsigned   idle_cycles;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic calib_result_t status_of(logic frame, logic [7:0] b, logic lst,
                                              int unsigned bin, logic ok);
    calib_result_t r;
    r.is_frame    = frame;
    r.out_byte    = b;
    r.last        = lst;
    r.mode        = cur_mode;
    r.bin_index   = bin[6:0];
    r.filled_bins = nfilled[6:0];
    r.coverage_ok = ok;
    r.low_one     = lo1[12:0];
    r.high_one    = hi1[12:0];
    r.low_two     = lo2[12:0];
    r.high_two    = hi2[12:0];
    return r;
  endfunction

  function automatic int unsigned bin_for(int unsigned p);
    int unsigned idx;
    if (hi1 <= lo1 || p <= lo1) return 0;
    idx = ((p - lo1) * NBINS) / (hi1 - lo1);
    return (idx > NBINS - 1) ? NBINS - 1 : idx;
  endfunction

  function automatic bit gaps_small_enough();
    int unsigned s, c;
    s = NBINS;
    c = 1;
    foreach (fill_cnt[i]) if (fill_cnt[i] != 0) c++;
    if (fill_cnt[NBINS-1] == 0) s++;
    return (10 * s) < (gap_limit * c);
  endfunction

  function automatic void calib_reset();
    gap_limit   = 13;
    cap_per_bin = 5;
    period      = 5;
    cur_mode    = MODE_CHAR;
    lo1 = 0; hi1 = FULL; lo2 = 0; hi2 = FULL;
    foreach (fill_cnt[i]) begin
      mean_one[i] = 0; mean_two[i] = 0; fill_cnt[i] = 0;
    end
    nfilled    = 0;
    period_cnt = 1;
  endfunction

  // Work out the results one accepted item causes and queue them
  function automatic void calib_predict(logic op, int unsigned p1, int unsigned p2,
                                        int unsigned ang);
    logic [7:0] fb [16];
    int unsigned sum, bin, n;
    logic ok;
    bin = 0;
    ok  = 1'b0;
    if (op) begin
      if (cur_mode == MODE_RUN) begin
        hi1 = 0; lo1 = FULL; hi2 = 0; lo2 = FULL;
      end
      cur_mode = MODE_RANGE;
      pending_results.push_back(status_of(1'b0, 8'h00, 1'b1, 0, 1'b0));
      return;
    end
    if (cur_mode == MODE_RUN) begin
      for (int i = 0; i < 7; i++) fb[i] = SYNC_BYTE;
      fb[7]  = START_BYTE;
      fb[8]  = ang[15:8];  fb[9]  = ang[7:0];
      fb[10] = p1[15:8];   fb[11] = p1[7:0];
      fb[12] = p2[15:8];   fb[13] = p2[7:0];
      sum = fb[8] + fb[9] + fb[10] + fb[11] + fb[12] + fb[13];
      fb[14] = sum[7:0];
      fb[15] = END_BYTE;
      for (int i = 0; i < 16; i++)
        pending_results.push_back(status_of(1'b1, fb[i], i == 15, 0, 1'b0));
      return;
    end
    if (cur_mode == MODE_RANGE) begin
      if (p1 > hi1) hi1 = p1;
      if (p1 < lo1) lo1 = p1;
      if (p2 > hi2) hi2 = p2;
      if (p2 < lo2) lo2 = p2;
    end else if (cur_mode == MODE_CHAR) begin
      bin = bin_for(p1);
      n   = fill_cnt[bin];
      if (n < cap_per_bin) begin
        if (n == 0) nfilled++;
        mean_one[bin] = ((mean_one[bin] * n + p1) / (n + 1)) & 16'hFFFF;
        mean_two[bin] = ((mean_two[bin] * n + p2) / (n + 1)) & 16'hFFFF;
        fill_cnt[bin] = (n + 1) & 7'h7F;
      end
      if (period_cnt == period) begin
        period_cnt = 1;
        if (gaps_small_enough()) begin
          ok = 1'b1;
          cur_mode = MODE_SAVED;
          saves_seen++;
        end
      end else begin
        period_cnt = (period_cnt + 1) & 8'hFF;
      end
    end
    pending_results.push_back(status_of(1'b0, 8'h00, 1'b1, bin, ok));
  endfunction

  // Send one item, with bursts of transfers separated by random gaps
  task automatic send_item(logic op, int unsigned p1, int unsigned p2, int unsigned ang);
    if (burst_left == 0) begin
      int unsigned gap;
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    op_i       <= op;
    pot_one_i  <= p1[SBITS-1:0];
    pot_two_i  <= p2[SBITS-1:0];
    angle_i    <= ang[SBITS-1:0];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    calib_predict(op, p1[SBITS-1:0], p2[SBITS-1:0], ang[SBITS-1:0]);
    items_sent++;
  endtask

  task automatic send_random_sample();
    send_item(1'b0, $urandom_range(0, FULL - 1), $urandom_range(0, FULL - 1),
              $urandom_range(0, FULL - 1));
  endtask

  // Register writes only once every queued result is out and the block is idle
  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_GAP:    gap_limit   = data[6:0];
      CFG_MAXBIN: cap_per_bin = data[6:0];
      CFG_PERIOD: period      = data;
      default:    ;
    endcase
  endtask

  // Receiver: check each transfer, then pick next ready (pattern or hold-off)
  always @(posedge clk_i) begin
    calib_result_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{is_frame_o, out_byte_o, last_o, mode_o, bin_index_o, filled_bins_o,
              coverage_ok_o, low_one_o, high_one_o, low_two_o, high_two_o};
      results_seen++;
      if (got.is_frame) frames_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("[%0t] unexpected result %h", $realtime, got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (mismatches < 10)
            $display("[%0t] mismatch: exp frm=%b byte=%h last=%b mode=%0d bin=%0d fill=%0d ok=%b ext=%0d/%0d/%0d/%0d\n               got frm=%b byte=%h last=%b mode=%0d bin=%0d fill=%0d ok=%b ext=%0d/%0d/%0d/%0d",
                     $realtime, want.is_frame, want.out_byte, want.last, want.mode,
                     want.bin_index, want.filled_bins, want.coverage_ok, want.low_one,
                     want.high_one, want.low_two, want.high_two, got.is_frame,
                     got.out_byte, got.last, got.mode, got.bin_index, got.filled_bins,
                     got.coverage_ok, got.low_one, got.high_one, got.low_two,
                     got.high_two);
          mismatches++;
        end
      end
    end
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 3) != 0) || ($time % 2000 < 400);
    end
  end

  // Watchdog: cycles without any transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Defaults, corner pot values and the first coverage check
  task automatic test_char_corners();
    send_item(1'b0, 0, 0, 0);
    send_item(1'b0, FULL - 1, FULL - 1, FULL - 1);
    send_item(1'b0, 2048, 1, 4094);
    send_item(1'b0, 1, 4094, 1);
    send_item(1'b0, 4094, 2048, 2048);
    send_item(1'b0, 40, 7, 2730);
  endtask

  // Per-bin cap, including a masked-to-zero cap, and every register
  task automatic test_bin_cap();
    write_reg(CFG_GAP, 8'd1);
    write_reg(CFG_MAXBIN, 8'd1);
    write_reg(CFG_PERIOD, 8'd1);
    repeat (3) send_item(1'b0, 1000, $urandom_range(0, FULL - 1), 0);
    write_reg(CFG_MAXBIN, 8'h80);
    repeat (2) send_item(1'b0, 3000, 5, 1365);
    write_reg(CFG_MAXBIN, 8'd127);
    write_reg(CFG_PERIOD, 8'd255);
    write_reg(2'd3, 8'hFF);
    repeat (6) send_item(1'b0, 1000, $urandom_range(0, FULL - 1), 0);
  endtask

  // Random characterization samples with a long output hold-off at the start
  task automatic test_char_random();
    hold_cycles = 300;
    repeat (45) send_random_sample();
    write_reg(CFG_MAXBIN, 8'd3);
    write_reg(CFG_PERIOD, 8'd7);
    repeat (45) send_random_sample();
  endtask

  // Loose gap limit and check every sample: send until saved mode (at most 40 tries)
  task automatic test_coverage_save();
    int unsigned tries;
    write_reg(CFG_GAP, 8'd100);
    write_reg(CFG_PERIOD, 8'd1);
    write_reg(CFG_MAXBIN, 8'd5);
    tries = 0;
    while (cur_mode == MODE_CHAR && tries < 40) begin
      send_random_sample();
      tries++;
    end
    repeat (6) send_random_sample();
  endtask

  // A press into range mode, then range samples, a second press and more samples
  task automatic test_press_range();
    send_item(1'b1, $urandom_range(0, FULL - 1), $urandom_range(0, FULL - 1), 0);
    repeat (10) send_random_sample();
    send_item(1'b1, FULL - 1, FULL - 1, FULL - 1);
    repeat (6) send_random_sample();
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    op_i        = 1'b0;
    pot_one_i   = '0;
    pot_two_i   = '0;
    angle_i     = '0;
    out_ready_i = 1'b0;
    errors = 0; mismatches = 0; items_sent = 0; results_seen = 0;
    frames_seen = 0; saves_seen = 0; burst_left = 0; hold_cycles = 0;
    idle_cycles = 0;
    calib_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_char_corners();
    test_bin_cap();
    test_char_random();
    test_coverage_save();
    test_press_range();

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) errors++;

    $display("Sent %0d items, checked %0d results (%0d frame bytes, %0d saves).",
             items_sent, results_seen, frames_seen, saves_seen);
    $display("Covered bin caps, coverage checks, saved mode and range-mode presses.");
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d errors (%0d mismatches)", errors, mismatches);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
